### hdl/dspq_pkg.sv
package dspq_pkg;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_PEEK   = 2'd2;

   localparam int VALUE_WIDTH     = 32;
   localparam int OCCUPANCY_WIDTH = 5;

   typedef struct packed {
      logic load_ins;   // latch value, index <= count
      logic load_head;  // index <= 0
      logic clr_result;
      logic rd_head;    // read slot 0
      logic rd_prev;    // read slot index-1
      logic rd_next;    // read slot index+1
      logic wr_up;      // slot index <= read data, index--
      logic wr_down;    // slot index <= read data, index++
      logic wr_val;     // slot index <= latched value
      logic take_head;  // result <= read data
      logic cnt_inc;
      logic cnt_dec;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic at_zero;    // index == 0
      logic at_last;    // index == count-1
      logic ge;         // read data >= latched value, signed
   } dp_status_type;

endpackage

### hdl/dspq_datapath.sv
module dspq_datapath #(
   parameter int CAPACITY = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  dspq_pkg::dp_cmd_type                       cmd,
   output dspq_pkg::dp_status_type                    status,
   input  logic signed [dspq_pkg::VALUE_WIDTH-1:0]    req_value,
   output logic signed [dspq_pkg::VALUE_WIDTH-1:0]    result_value,
   output logic [dspq_pkg::OCCUPANCY_WIDTH-1:0]       occupancy
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   logic [dspq_pkg::VALUE_WIDTH-1:0] mem [CAPACITY];

   logic [CW-1:0]                         count_ff, count_in;
   logic [AW-1:0]                         idx_ff, idx_in;
   logic signed [dspq_pkg::VALUE_WIDTH-1:0] val_ff;
   logic signed [dspq_pkg::VALUE_WIDTH-1:0] rdata_ff;
   logic signed [dspq_pkg::VALUE_WIDTH-1:0] result_ff;
   logic [AW-1:0]                         raddr;
   logic                                  rd_en;
   logic                                  wr_en;
   logic [dspq_pkg::VALUE_WIDTH-1:0]      wdata;

   always_comb begin
      raddr = '0;
      if (cmd.rd_prev) begin
         raddr = idx_ff - AW'(1);
      end else if (cmd.rd_next) begin
         raddr = idx_ff + AW'(1);
      end
      rd_en = cmd.rd_head | cmd.rd_prev | cmd.rd_next;
      wr_en = cmd.wr_up | cmd.wr_down | cmd.wr_val;
      wdata = cmd.wr_val ? val_ff : rdata_ff;
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load_ins) begin
         idx_in = count_ff[AW-1:0];
      end else if (cmd.load_head) begin
         idx_in = '0;
      end else if (cmd.wr_up) begin
         idx_in = idx_ff - AW'(1);
      end else if (cmd.wr_down) begin
         idx_in = idx_ff + AW'(1);
      end
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load_ins) begin
         val_ff <= req_value;
      end
      if (cmd.clr_result) begin
         result_ff <= '0;
      end else if (cmd.take_head) begin
         result_ff <= rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_ff] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_comb begin
      status.full    = (count_ff == CAP_COUNT);
      status.empty   = (count_ff == '0);
      status.at_zero = (idx_ff == '0);
      status.at_last = ((CW'(idx_ff) + CW'(1)) == count_ff);
      status.ge      = (rdata_ff >= val_ff);
   end

   assign result_value = result_ff;
   assign occupancy    = dspq_pkg::OCCUPANCY_WIDTH'(count_ff);

endmodule

### hdl/dspq_ctrl.sv
module dspq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [1:0]              req_operation,
   output logic                    busy,
   output dspq_pkg::dp_cmd_type    cmd,
   input  dspq_pkg::dp_status_type status,
   output logic                    rsp_valid,
   output logic                    rsp_was_empty,
   output logic                    rsp_overflowed
);

   typedef enum logic [2:0] {
      IDLE,
      INS_CHECK,
      INS_CMP,
      HEAD,
      REM_SHIFT,
      REM_CHECK
   } state_type;

   state_type state_ff, state_in;
   logic      peek_ff, peek_in;
   logic      valid_in, empty_in, over_in;
   logic      accept;

   assign accept = start & ~busy;
   assign busy   = (state_ff != IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      peek_in  = peek_ff;
      valid_in = 1'b0;
      empty_in = 1'b0;
      over_in  = 1'b0;
      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               cmd.clr_result = 1'b1;
               priority if (req_operation == dspq_pkg::OP_INSERT) begin
                  if (status.full) begin
                     valid_in = 1'b1;
                     over_in  = 1'b1;
                  end else begin
                     cmd.load_ins = 1'b1;
                     state_in     = INS_CHECK;
                  end
               end else if (req_operation == dspq_pkg::OP_REMOVE ||
                            req_operation == dspq_pkg::OP_PEEK) begin
                  if (status.empty) begin
                     valid_in = 1'b1;
                     empty_in = 1'b1;
                  end else begin
                     cmd.load_head = 1'b1;
                     cmd.rd_head   = 1'b1;
                     peek_in       = (req_operation == dspq_pkg::OP_PEEK);
                     state_in      = HEAD;
                  end
               end else begin
                  valid_in = 1'b1;
               end
            end
         end
         INS_CHECK: begin
            if (status.at_zero) begin
               cmd.wr_val  = 1'b1;
               cmd.cnt_inc = 1'b1;
               valid_in    = 1'b1;
               state_in    = IDLE;
            end else begin
               cmd.rd_prev = 1'b1;
               state_in    = INS_CMP;
            end
         end
         INS_CMP: begin
            if (status.ge) begin
               cmd.wr_val  = 1'b1;
               cmd.cnt_inc = 1'b1;
               valid_in    = 1'b1;
               state_in    = IDLE;
            end else begin
               cmd.wr_up = 1'b1;
               state_in  = INS_CHECK;
            end
         end
         HEAD: begin
            cmd.take_head = 1'b1;
            if (peek_ff) begin
               valid_in = 1'b1;
               state_in = IDLE;
            end else if (status.at_last) begin
               cmd.cnt_dec = 1'b1;
               valid_in    = 1'b1;
               state_in    = IDLE;
            end else begin
               cmd.rd_next = 1'b1;
               state_in    = REM_SHIFT;
            end
         end
         REM_SHIFT: begin
            cmd.wr_down = 1'b1;
            state_in    = REM_CHECK;
         end
         REM_CHECK: begin
            if (status.at_last) begin
               cmd.cnt_dec = 1'b1;
               valid_in    = 1'b1;
               state_in    = IDLE;
            end else begin
               cmd.rd_next = 1'b1;
               state_in    = REM_SHIFT;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= IDLE;
         peek_ff        <= 1'b0;
         rsp_valid      <= 1'b0;
         rsp_was_empty  <= 1'b0;
         rsp_overflowed <= 1'b0;
      end else begin
         state_ff       <= state_in;
         peek_ff        <= peek_in;
         rsp_valid      <= valid_in;
         rsp_was_empty  <= empty_in;
         rsp_overflowed <= over_in;
      end
   end

endmodule

### hdl/descending_sorted_priority_queue.sv
// Sorted priority queue of signed 32-bit values, largest first.
// Request: pulse start with req_operation (insert, remove, peek) and req_value
// while busy is low; the request is taken at that clock edge.
// Response: rsp_valid is high for one cycle with rsp_result_value,
// rsp_was_empty, rsp_overflowed and rsp_occupancy (count after the request).
// Equal values leave in arrival order.
// Steps after the accept edge:
//   dropped insert, empty remove/peek, unused code: answered from IDLE
//   peek: the head is read, then answered from HEAD
//   insert: from the tail, each stored value smaller than the new one is
//     read and moved one slot toward the tail; then the new value is written
//   remove: the head is taken, then each later entry moves one slot toward the head
// The values live in a single-port-write, registered-read memory; every entry
// moved takes a read and then a write.
// busy falls in the strobe cycle, so a new request may be taken then.
// Only one request is in flight at a time.
// Reset empties the queue at once; memory contents are not cleared.
// The receiver cannot stall; each response is shown once.
module descending_sorted_priority_queue #(
   parameter int CAPACITY = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_operation,
   input  logic signed [31:0]   req_value,
   output logic                 rsp_valid,
   output logic signed [31:0]   rsp_result_value,
   output logic                 rsp_was_empty,
   output logic                 rsp_overflowed,
   output logic [4:0]           rsp_occupancy
);

   dspq_pkg::dp_cmd_type    cmd;
   dspq_pkg::dp_status_type status;

   dspq_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_operation  (req_operation),
      .busy           (busy),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_was_empty  (rsp_was_empty),
      .rsp_overflowed (rsp_overflowed)
   );

   dspq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_value    (req_value),
      .result_value (rsp_result_value),
      .occupancy    (rsp_occupancy)
   );

   localparam logic [4:0] CAP_OCC = 5'(CAPACITY);

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflowed |-> rsp_occupancy == CAP_OCC && rsp_result_value == 0)
      else $error("overflow reported with queue not full");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_empty |-> rsp_occupancy == 5'd0 && rsp_result_value == 0)
      else $error("empty reported with entries stored or nonzero result");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_was_empty && rsp_overflowed))
      else $error("empty and overflow flagged together");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("accepted request neither busy nor answered");

endmodule
